// ===== rtl/aavr_pkg.sv =====
// Shared types, constants and the arctangent table for the axis-angle rotator.
// No dependencies; every other RTL file but aavr_if refers to it by scoped names.
`default_nettype none

package aavr_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int SQRT_BITS        = 32;   // bits of the integer square root
    localparam int QUOT_BITS        = 31;   // quotient bits of the unit-axis divide
    localparam int CW               = 34;   // CORDIC datapath width

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic        [31:0] angle;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } t_item;

    // Carried along the whole chain next to the working data.
    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic        [31:0] angle;
        logic        [2:0]  neg;
        logic               zero;
    } t_side;

    typedef struct packed {
        t_side                side;
        logic [2:0][31:0]     mag;
        logic [63:0]          rem;
        logic [SQRT_BITS-1:0] root;
    } t_sqrt;

    typedef struct packed {
        t_side                     side;
        logic [31:0]               den;
        logic [2:0][31:0]          mag;
        logic [2:0][31:0]          rem;
        logic [2:0][QUOT_BITS-1:0] quo;
    } t_div;

    typedef struct packed {
        t_side              side;
        logic [2:0][31:0]   w;
        logic               flip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cor;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               axis_zero;
    } t_res;

    // arctan(2^-i) in binary-angle units, 2^32 per turn
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            5'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/aavr_if.sv =====
// Valid/ready channel interfaces for the input and result words.
// No dependencies.
`default_nettype none

interface aavr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic        [31:0] angle;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;

    modport source (output valid, axis_x, axis_y, axis_z, angle, vec_x, vec_y, vec_z,
                    input ready);
    modport sink   (input valid, axis_x, axis_y, axis_z, angle, vec_x, vec_y, vec_z,
                    output ready);
endinterface

interface aavr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               axis_zero;

    modport source (output valid, rot_x, rot_y, rot_z, axis_zero, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, axis_zero, output ready);
endinterface

`default_nettype wire

// ===== rtl/axis_angle_vector_rotate.sv =====
// Top level: axis-angle (Rodrigues) rotation of a 3D vector, fully pipelined.
// Depends on aavr_pkg, aavr_if, aavr_front, aavr_sqrt_cell, aavr_div_cell,
// aavr_cordic_cell and aavr_back.
//
//  channel | dir | fields                                          | handshake
//  --------+-----+-------------------------------------------------+------------
//  i_in    | in  | axis_x/y/z, angle, vec_x/y/z                    | valid/ready
//  o_out   | out | rot_x/y/z, axis_zero                            | valid/ready
//
// One word in and one word out per cycle while the output is not stalled. The
// chain is prescale, one square-root cell per root bit, one divider cell per
// quotient bit, one CORDIC cell per iteration, matrix stages, output register.
// Reset clears every valid bit; payload registers are not reset.
// The chain advances as a whole while the skid register is empty; a stalled
// output fills the skid register and then freezes the chain and drops i_in.ready.
`default_nettype none

module axis_angle_vector_rotate #(
    parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    aavr_in_if.sink    i_in,
    aavr_out_if.source o_out
);

    localparam int NS = aavr_pkg::SQRT_BITS;
    localparam int ND = aavr_pkg::QUOT_BITS;

    logic              en;
    aavr_pkg::t_item   in_item;

    logic              sq_v [NS+1];
    aavr_pkg::t_sqrt   sq_d [NS+1];
    logic              dv_v [ND+1];
    aavr_pkg::t_div    dv_d [ND+1];
    logic              cr_v [CORDIC_STEPS+1];
    aavr_pkg::t_cor    cr_d [CORDIC_STEPS+1];

    logic              p_valid;
    aavr_pkg::t_res    p_data;

    logic              r_out_valid;
    aavr_pkg::t_res    r_out;
    logic              r_skid_valid;
    aavr_pkg::t_res    r_skid;
    logic              n_out_valid;
    aavr_pkg::t_res    n_out;
    logic              n_skid_valid;
    aavr_pkg::t_res    n_skid;

    logic [31:0]       wq [3];
    logic [31:0]       res_ang;

    // hold the whole chain while the skid register is occupied
    assign en         = !r_skid_valid;
    assign i_in.ready = en;

    always_comb begin
        in_item.axis_x = i_in.axis_x;
        in_item.axis_y = i_in.axis_y;
        in_item.axis_z = i_in.axis_z;
        in_item.angle  = i_in.angle;
        in_item.vec_x  = i_in.vec_x;
        in_item.vec_y  = i_in.vec_y;
        in_item.vec_z  = i_in.vec_z;
    end

    aavr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_data  (in_item),
        .o_valid (sq_v[0]),
        .o_data  (sq_d[0])
    );

    // square root: one cell per root bit, most significant first
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        aavr_sqrt_cell #(.BIT(NS - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[k]),
            .i_data  (sq_d[k]),
            .o_valid (sq_v[k+1]),
            .o_data  (sq_d[k+1])
        );
    end

    // divider takes the norm as divisor
    always_comb begin
        dv_v[0]      = sq_v[NS];
        dv_d[0].side = sq_d[NS].side;
        dv_d[0].den  = sq_d[NS].root;
        dv_d[0].mag  = sq_d[NS].mag;
        dv_d[0].rem  = '0;
        dv_d[0].quo  = '0;
    end

    // unit axis = |a| * 2^30 / n, integer quotient bit first
    for (genvar k = 0; k < ND; k++) begin : g_div
        aavr_div_cell #(.FIRST(k == 0)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[k]),
            .i_data  (dv_d[k]),
            .o_valid (dv_v[k+1]),
            .o_data  (dv_d[k+1])
        );
    end

    // restore signs, fold the angle into the right half plane, seed the CORDIC
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wq[i] = {1'b0, dv_d[ND].quo[i]};
            cr_d[0].w[i] = dv_d[ND].side.neg[i] ? (~wq[i] + 32'd1) : wq[i];
        end
        cr_v[0]      = dv_v[ND];
        cr_d[0].side = dv_d[ND].side;
        cr_d[0].flip = (dv_d[ND].side.angle - 32'h4000_0000) < 32'h8000_0000;
        res_ang      = cr_d[0].flip ? (dv_d[ND].side.angle + 32'h8000_0000)
                                    : dv_d[ND].side.angle;
        cr_d[0].x    = aavr_pkg::CORDIC_GAIN;
        cr_d[0].y    = '0;
        cr_d[0].z    = {{(aavr_pkg::CW - 32){res_ang[31]}}, res_ang};
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        aavr_cordic_cell #(.STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cr_v[k]),
            .i_data  (cr_d[k]),
            .o_valid (cr_v[k+1]),
            .o_data  (cr_d[k+1])
        );
    end

    aavr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cr_v[CORDIC_STEPS]),
        .i_data  (cr_d[CORDIC_STEPS]),
        .o_valid (p_valid),
        .o_data  (p_data)
    );

    // output register with skid: drain the skid first, else load the chain word
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || o_out.ready) begin
            n_out_valid  = r_skid_valid || p_valid;
            n_out        = r_skid_valid ? r_skid : p_data;
            n_skid_valid = 1'b0;
        end else if (p_valid && en) begin
            n_skid       = p_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.rot_x     = r_out.rot_x;
    assign o_out.rot_y     = r_out.rot_y;
    assign o_out.rot_z     = r_out.rot_z;
    assign o_out.axis_zero = r_out.axis_zero;

endmodule

`default_nettype wire

// ===== rtl/aavr_front.sv =====
// Axis magnitudes, common prescale and sum of squares (four stages).
// Depends on aavr_pkg.
`default_nettype none

module aavr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire aavr_pkg::t_item i_data,
    output logic               o_valid,
    output aavr_pkg::t_sqrt    o_data
);

    logic [3:0]        r_v;
    aavr_pkg::t_side   r_side [4];
    logic [31:0]       r_mag1 [3];
    logic [31:0]       r_mag2 [3];
    logic [31:0]       r_mag3 [3];
    logic [63:0]       r_sq3  [3];
    aavr_pkg::t_sqrt   r_out;

    aavr_pkg::t_side   n_side;
    logic [31:0]       n_mag1 [3];
    logic [31:0]       n_mag2 [3];
    logic [31:0]       mx;
    logic [4:0]        n_shift;
    logic [31:0]       ax [3];

    // stage 1: magnitudes and signs
    always_comb begin
        ax[0] = i_data.axis_x;
        ax[1] = i_data.axis_y;
        ax[2] = i_data.axis_z;
        for (int i = 0; i < 3; i++) begin
            n_mag1[i] = ax[i][31] ? (~ax[i] + 32'd1) : ax[i];
        end
        n_side.vec_x = i_data.vec_x;
        n_side.vec_y = i_data.vec_y;
        n_side.vec_z = i_data.vec_z;
        n_side.angle = i_data.angle;
        n_side.neg   = {ax[2][31], ax[1][31], ax[0][31]};
        n_side.zero  = (ax[0] == 32'd0) && (ax[1] == 32'd0) && (ax[2] == 32'd0);
    end

    // stage 2: shift all three so the largest lands in [2^30, 2^31]
    always_comb begin
        mx = r_mag1[0];
        if (r_mag1[1] > mx) mx = r_mag1[1];
        if (r_mag1[2] > mx) mx = r_mag1[2];
        n_shift = 5'd0;
        for (int b = 0; b < 31; b++) begin
            if (mx[b]) n_shift = 5'(30 - b);
        end
        if (mx[31]) n_shift = 5'd0;
        for (int i = 0; i < 3; i++) begin
            n_mag2[i] = r_mag1[i] << n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= n_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
            for (int i = 0; i < 3; i++) begin
                r_mag1[i] <= n_mag1[i];
                r_mag2[i] <= n_mag2[i];
                r_mag3[i] <= r_mag2[i];
                r_sq3[i]  <= r_mag2[i] * r_mag2[i];
            end
            r_out.side <= r_side[2];
            r_out.mag  <= {r_mag3[2], r_mag3[1], r_mag3[0]};
            r_out.rem  <= r_sq3[0] + r_sq3[1] + r_sq3[2];
            r_out.root <= '0;
        end
    end

    assign o_valid = r_v[3];
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/aavr_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit.
// Depends on aavr_pkg.
`default_nettype none

module aavr_sqrt_cell #(
    parameter int BIT = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire aavr_pkg::t_sqrt i_data,
    output logic               o_valid,
    output aavr_pkg::t_sqrt    o_data
);

    logic             r_valid;
    aavr_pkg::t_sqrt  r_data;
    aavr_pkg::t_sqrt  n_data;
    logic [65:0]      cand;

    // (root + 2^BIT)^2 - root^2, with the low root bits still zero
    always_comb begin
        cand   = (66'(i_data.root) << (BIT + 1)) + (66'd1 << (2 * BIT));
        n_data = i_data;
        if (66'(i_data.rem) >= cand) begin
            n_data.rem       = i_data.rem - cand[63:0];
            n_data.root[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/aavr_div_cell.sv =====
// One cell of the restoring divider chain: one quotient bit for each axis lane.
// Depends on aavr_pkg.
`default_nettype none

module aavr_div_cell #(
    parameter bit FIRST = 1'b0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire aavr_pkg::t_div i_data,
    output logic               o_valid,
    output aavr_pkg::t_div     o_data
);

    logic             r_valid;
    aavr_pkg::t_div   r_data;
    aavr_pkg::t_div   n_data;
    logic [32:0]      r2 [3];
    logic             qb [3];

    always_comb begin
        n_data = i_data;
        for (int i = 0; i < 3; i++) begin
            r2[i] = FIRST ? {1'b0, i_data.mag[i]} : {i_data.rem[i], 1'b0};
            qb[i] = (r2[i] >= {1'b0, i_data.den});
            n_data.rem[i] = qb[i] ? 32'(r2[i] - {1'b0, i_data.den}) : r2[i][31:0];
            n_data.quo[i] = {i_data.quo[i][aavr_pkg::QUOT_BITS-2:0], qb[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/aavr_cordic_cell.sv =====
// One rotation-mode CORDIC iteration.
// Depends on aavr_pkg.
`default_nettype none

module aavr_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire aavr_pkg::t_cor i_data,
    output logic               o_valid,
    output aavr_pkg::t_cor     o_data
);

    logic                             r_valid;
    aavr_pkg::t_cor                   r_data;
    aavr_pkg::t_cor                   n_data;
    logic signed [aavr_pkg::CW-1:0]   dx;
    logic signed [aavr_pkg::CW-1:0]   dy;
    logic signed [aavr_pkg::CW-1:0]   ang;

    always_comb begin
        dx     = i_data.y >>> STEP;
        dy     = i_data.x >>> STEP;
        ang    = $signed({2'b00, aavr_pkg::atan_lut(5'(STEP))});
        n_data = i_data;
        if (!i_data.z[aavr_pkg::CW-1]) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ang;
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/aavr_back.sv =====
// Rotation matrix and matrix-vector product (six stages), zero-axis bypass.
// Depends on aavr_pkg.
`default_nettype none

module aavr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire aavr_pkg::t_cor i_data,
    output logic               o_valid,
    output aavr_pkg::t_res     o_data
);

    function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd1073741824)       r = 32'sd1073741824;
        else if (v < -34'sd1073741824) r = -32'sd1073741824;
        else                           r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = (p + 64'sd536870912) >>> 30;
        return p[31:0];
    endfunction

    function automatic logic signed [32:0] mul_q30_t(input logic signed [31:0] a,
                                                     input logic signed [32:0] b);
        logic signed [64:0] p;
        p = a * b;
        p = (p + 65'sd536870912) >>> 30;
        return p[32:0];
    endfunction

    logic [5:0]            r_v;
    aavr_pkg::t_side       r_side [5];
    // stage 0
    logic signed [31:0]    r0_c;
    logic signed [31:0]    r0_s;
    logic signed [32:0]    r0_t;
    logic signed [31:0]    r0_w [3];
    // stage 1: u_i*u_j (xx yy zz xy xz yz) and u_i*sin
    logic signed [31:0]    r1_uu [6];
    logic signed [31:0]    r1_us [3];
    logic signed [31:0]    r1_c;
    logic signed [32:0]    r1_t;
    // stage 2
    logic signed [32:0]    r2_ut [6];
    logic signed [31:0]    r2_us [3];
    logic signed [31:0]    r2_c;
    // stage 3
    logic signed [31:0]    r3_m  [9];
    // stage 4
    logic signed [63:0]    r4_p  [9];
    // stage 5
    aavr_pkg::t_res        r_out;

    logic signed [33:0]    xf;
    logic signed [33:0]    yf;
    logic signed [31:0]    n0_c;
    logic signed [33:0]    m_raw [9];
    logic signed [31:0]    vv [3];
    logic signed [65:0]    acc [3];
    logic signed [31:0]    rot [3];

    always_comb begin
        xf   = i_data.flip ? -i_data.x : i_data.x;
        yf   = i_data.flip ? -i_data.y : i_data.y;
        n0_c = clamp_one(xf);
    end

    // matrix entries from the rounded products
    always_comb begin
        m_raw[0] = r2_c + r2_ut[0];
        m_raw[1] = r2_ut[3] - r2_us[2];
        m_raw[2] = r2_ut[4] + r2_us[1];
        m_raw[3] = r2_ut[3] + r2_us[2];
        m_raw[4] = r2_c + r2_ut[1];
        m_raw[5] = r2_ut[5] - r2_us[0];
        m_raw[6] = r2_ut[4] - r2_us[1];
        m_raw[7] = r2_ut[5] + r2_us[0];
        m_raw[8] = r2_c + r2_ut[2];
    end

    always_comb begin
        vv[0] = r_side[3].vec_x;
        vv[1] = r_side[3].vec_y;
        vv[2] = r_side[3].vec_z;
        for (int j = 0; j < 3; j++) begin
            acc[j] = r4_p[3*j] + r4_p[3*j+1] + r4_p[3*j+2] + 66'sd536870912;
            acc[j] = acc[j] >>> 30;
            if (acc[j] > 66'sd2147483647)       rot[j] = 32'sh7FFFFFFF;
            else if (acc[j] < -66'sd2147483648) rot[j] = 32'sh80000000;
            else                                rot[j] = acc[j][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_data.side;
            for (int k = 1; k < 5; k++) r_side[k] <= r_side[k-1];

            r0_c <= n0_c;
            r0_s <= clamp_one(yf);
            r0_t <= 33'sd1073741824 - 33'(n0_c);
            for (int i = 0; i < 3; i++) r0_w[i] <= i_data.w[i];

            r1_uu[0] <= mul_q30(r0_w[0], r0_w[0]);
            r1_uu[1] <= mul_q30(r0_w[1], r0_w[1]);
            r1_uu[2] <= mul_q30(r0_w[2], r0_w[2]);
            r1_uu[3] <= mul_q30(r0_w[0], r0_w[1]);
            r1_uu[4] <= mul_q30(r0_w[0], r0_w[2]);
            r1_uu[5] <= mul_q30(r0_w[1], r0_w[2]);
            for (int i = 0; i < 3; i++) r1_us[i] <= mul_q30(r0_w[i], r0_s);
            r1_c <= r0_c;
            r1_t <= r0_t;

            for (int i = 0; i < 6; i++) r2_ut[i] <= mul_q30_t(r1_uu[i], r1_t);
            for (int i = 0; i < 3; i++) r2_us[i] <= r1_us[i];
            r2_c <= r1_c;

            for (int i = 0; i < 9; i++) r3_m[i] <= clamp_one(m_raw[i]);

            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r4_p[3*j+i] <= r3_m[3*j+i] * vv[i];
                end
            end

            // zero axis: hand the vector through untouched
            r_out.rot_x     <= r_side[4].zero ? r_side[4].vec_x : rot[0];
            r_out.rot_y     <= r_side[4].zero ? r_side[4].vec_y : rot[1];
            r_out.rot_z     <= r_side[4].zero ? r_side[4].vec_z : rot[2];
            r_out.axis_zero <= r_side[4].zero;
        end
    end

    assign o_valid = r_v[5];
    assign o_data  = r_out;

endmodule

`default_nettype wire
